// ===== design/dsp_pkg.sv =====
// Shared constants, types and helpers for the shortest-path engine.
package dsp_pkg;

  localparam int MAX_NODES  = 1024;
  localparam int MAX_EDGES  = 4096;
  localparam int HEAP_DEPTH = 4096;
  localparam int DIST_W     = 32;

  localparam int NODE_W   = $clog2(MAX_NODES);
  localparam int NCNT_W   = NODE_W + 1;
  localparam int PRED_W   = NODE_W + 1;
  localparam int EDGE_W   = $clog2(MAX_EDGES);
  localparam int EPTR_W   = EDGE_W + 1;
  localparam int HEAP_W   = $clog2(HEAP_DEPTH);
  localparam int HFILL_W  = HEAP_W + 1;
  localparam int WGT_W    = 16;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 2;
  localparam int MODE_W   = 2;
  localparam int COST_W   = 32;
  localparam int CFG_W    = 32;
  localparam int CFGA_W   = 2;

  localparam int HENT_W = DIST_W + NODE_W;
  localparam int EENT_W = NODE_W + WGT_W + EPTR_W;
  localparam int NENT_W = DIST_W + PRED_W;

  localparam logic [DIST_W-1:0] DIST_INF  = '1;
  localparam logic [EPTR_W-1:0] EDGE_END  = EPTR_W'(MAX_EDGES);
  localparam logic [PRED_W-1:0] NODE_NONE = PRED_W'(MAX_NODES);
  localparam logic [NODE_W-1:0] NODE_LAST = NODE_W'(MAX_NODES - 1);

  localparam logic [MODE_W-1:0] MODE_STOP    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WITNESS = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_RUN   = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EDGE_FULL = 2'd1,
    ST_RANGE     = 2'd2,
    ST_HEAP_OVF  = 2'd3
  } status_t;

  typedef enum logic [CFGA_W-1:0] {
    CFG_MODE        = 2'd0,
    CFG_COST_LIMIT  = 2'd1,
    CFG_MAX_SETTLED = 2'd2,
    CFG_NODE_COUNT  = 2'd3
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_RST_CLR, S_IDLE, S_CLR, S_LOAD_D, S_READ_D, S_RUN_CLR,
    S_POP_CHK, S_POP_TOP, S_POP_LAST, S_SD_L, S_SD_R, S_SD_DEC,
    S_CHK, S_CHK_D, S_HEAD_D, S_EDGE, S_EDGE_D, S_RELAX,
    S_SU, S_SU_D, S_FIN, S_FIN_D, S_DONE
  } state_t;

  // Path sum that saturates one below the unreached value.
  function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] d,
                                                input logic [WGT_W-1:0] w);
    logic [DIST_W:0] sum;
    sum = {1'b0, d} + (DIST_W+1)'(w);
    if (sum >= {1'b0, DIST_INF}) sat_add = DIST_INF - 1'b1;
    else sat_add = sum[DIST_W-1:0];
  endfunction

endpackage

// ===== design/dsp_ram.sv =====
// Generic single-port-write, registered-read memory.
module dsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== design/dijkstra_shortest_path.sv =====
// Top level of the shortest-path engine: control sequencer, memories, result register.
//
//  channel | direction | handshake           | payload
//  in_     | request   | in_valid / in_stall   | cmd, from_node, to_node, edge_weight
//  out_    | result    | out_valid / out_stall | status, distance, predecessor, found,
//          |           |                       | settled_count
//  cfg_    | write     | cfg_we                | cfg_addr, cfg_wdata
//
// Load and read requests pass through a data state and the done state; a clear
// sweeps the list head table first. A run sweeps the node table, then pops the
// heap and relaxes each edge of a popped node; the single read port of the heap
// memory sets the sift step cost. After reset the block sweeps the list head and
// node tables with in_stall high. A result waits in the output register under
// out_stall while the block takes the next request.
module dijkstra_shortest_path (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [dsp_pkg::CMD_W-1:0]         in_cmd,
  input  logic [dsp_pkg::NODE_W-1:0]        in_from_node,
  input  logic [dsp_pkg::NODE_W-1:0]        in_to_node,
  input  logic [dsp_pkg::WGT_W-1:0]         in_edge_weight,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [dsp_pkg::STAT_W-1:0]        out_status,
  output logic [dsp_pkg::DIST_W-1:0]        out_distance,
  output logic [dsp_pkg::PRED_W-1:0]        out_predecessor,
  output logic                              out_found,
  output logic [dsp_pkg::NCNT_W-1:0]        out_settled_count,
  input  logic                              cfg_we,
  input  logic [dsp_pkg::CFGA_W-1:0]        cfg_addr,
  input  logic [dsp_pkg::CFG_W-1:0]         cfg_wdata
);
  import dsp_pkg::*;

  state_t state_r, state_nxt;

  logic [MODE_W-1:0] mode_r;
  logic [COST_W-1:0] cost_limit_r;
  logic [NCNT_W-1:0] max_settled_r, node_count_r;

  logic [NODE_W-1:0]  idx_r, idx_nxt;
  logic [NODE_W-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic [WGT_W-1:0]   w_r, w_nxt;
  logic [EPTR_W-1:0]  edge_total_r, edge_total_nxt;
  logic [HFILL_W-1:0] fill_r, fill_nxt;
  logic [NCNT_W-1:0]  settled_r, settled_nxt, last_settled_r, last_settled_nxt;
  logic               ovf_r, ovf_nxt;
  logic [DIST_W-1:0]  pop_d_r, pop_d_nxt, new_dist_r, new_dist_nxt;
  logic [NODE_W-1:0]  pop_u_r, pop_u_nxt, v_r, v_nxt;
  logic [HENT_W-1:0]  x_r, x_nxt, lval_r, lval_nxt;
  logic [HEAP_W-1:0]  hi_r, hi_nxt, li_r, li_nxt;
  logic               r_ok_r, r_ok_nxt;
  logic [EPTR_W-1:0]  e_r, e_nxt, next_r, next_nxt;

  status_t            res_status_r, res_status_nxt;
  logic [DIST_W-1:0]  res_dist_r, res_dist_nxt;
  logic [PRED_W-1:0]  res_pred_r, res_pred_nxt;
  logic               res_found_r, res_found_nxt;
  logic [NCNT_W-1:0]  res_cnt_r, res_cnt_nxt;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [DIST_W-1:0]  out_dist_r, out_dist_nxt;
  logic [PRED_W-1:0]  out_pred_r, out_pred_nxt;
  logic               out_found_r, out_found_nxt;
  logic [NCNT_W-1:0]  out_cnt_r, out_cnt_nxt;

  logic               lh_we;
  logic [NODE_W-1:0]  lh_wa, lh_ra;
  logic [EPTR_W-1:0]  lh_wd, lh_rd;
  logic               eg_we;
  logic [EDGE_W-1:0]  eg_wa, eg_ra;
  logic [EENT_W-1:0]  eg_wd, eg_rd;
  logic               nm_we;
  logic [NODE_W-1:0]  nm_wa, nm_ra;
  logic [NENT_W-1:0]  nm_wd, nm_rd;
  logic               hp_we;
  logic [HEAP_W-1:0]  hp_wa, hp_ra;
  logic [HENT_W-1:0]  hp_wd, hp_rd;

  dsp_ram #(.WIDTH(EPTR_W), .DEPTH(MAX_NODES)) u_list_head (
    .clk(clk), .we(lh_we), .waddr(lh_wa), .wdata(lh_wd), .raddr(lh_ra), .rdata(lh_rd));
  dsp_ram #(.WIDTH(EENT_W), .DEPTH(MAX_EDGES)) u_edges (
    .clk(clk), .we(eg_we), .waddr(eg_wa), .wdata(eg_wd), .raddr(eg_ra), .rdata(eg_rd));
  dsp_ram #(.WIDTH(NENT_W), .DEPTH(MAX_NODES)) u_nodes (
    .clk(clk), .we(nm_we), .waddr(nm_wa), .wdata(nm_wd), .raddr(nm_ra), .rdata(nm_rd));
  dsp_ram #(.WIDTH(HENT_W), .DEPTH(HEAP_DEPTH)) u_heap (
    .clk(clk), .we(hp_we), .waddr(hp_wa), .wdata(hp_wd), .raddr(hp_ra), .rdata(hp_rd));

  // Shared decode.
  logic [NCNT_W-1:0]  in_use;
  logic               a_oor, b_oor, edge_full, witness, stop_at, sweep_last, out_free;
  logic [DIST_W-1:0]  rd_dist;
  logic [PRED_W-1:0]  rd_pred;
  logic [HFILL_W-1:0] l_pos;
  logic               l_in, r_in;
  logic               l_lt_x, r_lt, sd_stop;
  logic [HENT_W-1:0]  best1;
  logic [HEAP_W-1:0]  parent;
  logic               stale, over_cost, hit_dst, better, heap_full, su_up, pop_gate;
  cmd_t               in_cmd_e;

  assign in_cmd_e   = cmd_t'(in_cmd);
  assign in_use     = (node_count_r > NCNT_W'(MAX_NODES)) ? NCNT_W'(MAX_NODES) : node_count_r;
  assign a_oor      = {1'b0, in_from_node} >= in_use;
  assign b_oor      = {1'b0, in_to_node} >= in_use;
  assign edge_full  = edge_total_r >= EDGE_END;
  assign witness    = (mode_r == MODE_WITNESS);
  assign stop_at    = (mode_r == MODE_STOP);
  assign sweep_last = (idx_r == NODE_LAST);
  assign out_free   = !out_valid_r || !out_stall;
  assign rd_dist    = nm_rd[NENT_W-1 -: DIST_W];
  assign rd_pred    = nm_rd[PRED_W-1:0];

  assign l_pos   = {hi_r, 1'b1};
  assign l_in    = l_pos < fill_r;
  assign r_in    = ({1'b0, l_pos} + 1'b1) < {1'b0, fill_r};
  assign l_lt_x  = lval_r < x_r;
  assign best1   = l_lt_x ? lval_r : x_r;
  assign r_lt    = r_ok_r && (hp_rd < best1);
  assign sd_stop = !l_lt_x && !r_lt;
  assign parent  = (hi_r - 1'b1) >> 1;

  assign stale     = pop_d_r > rd_dist;
  assign over_cost = witness && (pop_d_r > cost_limit_r);
  assign hit_dst   = stop_at && (pop_u_r == b_r);
  assign better    = new_dist_r < rd_dist;
  assign heap_full = fill_r >= HFILL_W'(HEAP_DEPTH);
  assign su_up     = x_r < hp_rd;
  assign pop_gate  = (fill_r == '0) || (witness && (settled_r >= max_settled_r));

  assign in_stall = (state_r != S_IDLE);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_RST_CLR: if (sweep_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          case (in_cmd_e)
            CMD_LOAD:  state_nxt = (a_oor || b_oor || edge_full) ? S_DONE : S_LOAD_D;
            CMD_CLEAR: state_nxt = S_CLR;
            CMD_RUN:   state_nxt = (a_oor || b_oor) ? S_DONE : S_RUN_CLR;
            CMD_READ:  state_nxt = a_oor ? S_DONE : S_READ_D;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLR:      if (sweep_last) state_nxt = S_DONE;
      S_LOAD_D:   state_nxt = S_DONE;
      S_READ_D:   state_nxt = S_DONE;
      S_RUN_CLR:  if (sweep_last) state_nxt = S_POP_CHK;
      S_POP_CHK:  state_nxt = pop_gate ? S_FIN : S_POP_TOP;
      S_POP_TOP:  state_nxt = S_POP_LAST;
      S_POP_LAST: state_nxt = (fill_r == '0) ? S_CHK : S_SD_L;
      S_SD_L:     state_nxt = l_in ? S_SD_R : S_CHK;
      S_SD_R:     state_nxt = S_SD_DEC;
      S_SD_DEC:   state_nxt = sd_stop ? S_CHK : S_SD_L;
      S_CHK:      state_nxt = S_CHK_D;
      S_CHK_D: begin
        if (stale) state_nxt = S_POP_CHK;
        else if (over_cost || hit_dst) state_nxt = S_FIN;
        else state_nxt = S_HEAD_D;
      end
      S_HEAD_D:   state_nxt = S_EDGE;
      S_EDGE:     state_nxt = (e_r >= EDGE_END) ? S_POP_CHK : S_EDGE_D;
      S_EDGE_D:   state_nxt = S_RELAX;
      S_RELAX:    state_nxt = (better && !heap_full) ? S_SU : S_EDGE;
      S_SU:       state_nxt = (hi_r == '0) ? S_EDGE : S_SU_D;
      S_SU_D:     state_nxt = su_up ? S_SU : S_EDGE;
      S_FIN:      state_nxt = S_FIN_D;
      S_FIN_D:    state_nxt = S_DONE;
      S_DONE:     if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Datapath, memory ports and result register.
  always_comb begin
    idx_nxt = idx_r;  a_nxt = a_r;  b_nxt = b_r;  w_nxt = w_r;
    edge_total_nxt = edge_total_r;  fill_nxt = fill_r;
    settled_nxt = settled_r;  last_settled_nxt = last_settled_r;  ovf_nxt = ovf_r;
    pop_d_nxt = pop_d_r;  pop_u_nxt = pop_u_r;  new_dist_nxt = new_dist_r;  v_nxt = v_r;
    x_nxt = x_r;  lval_nxt = lval_r;  hi_nxt = hi_r;  li_nxt = li_r;  r_ok_nxt = r_ok_r;
    e_nxt = e_r;  next_nxt = next_r;
    res_status_nxt = res_status_r;  res_dist_nxt = res_dist_r;  res_pred_nxt = res_pred_r;
    res_found_nxt = res_found_r;  res_cnt_nxt = res_cnt_r;
    out_valid_nxt = out_valid_r;  out_status_nxt = out_status_r;  out_dist_nxt = out_dist_r;
    out_pred_nxt = out_pred_r;  out_found_nxt = out_found_r;  out_cnt_nxt = out_cnt_r;
    lh_we = 1'b0;  lh_wa = idx_r;  lh_wd = EDGE_END;  lh_ra = a_r;
    eg_we = 1'b0;  eg_wa = edge_total_r[EDGE_W-1:0];  eg_wd = {b_r, w_r, lh_rd};
    eg_ra = e_r[EDGE_W-1:0];
    nm_we = 1'b0;  nm_wa = idx_r;  nm_wd = {DIST_INF, NODE_NONE};  nm_ra = a_r;
    hp_we = 1'b0;  hp_wa = hi_r;  hp_wd = x_r;  hp_ra = '0;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      S_RST_CLR: begin
        lh_we = 1'b1;
        nm_we = 1'b1;
        idx_nxt = idx_r + 1'b1;
      end
      S_IDLE: begin
        if (in_valid) begin
          a_nxt = in_from_node;
          b_nxt = in_to_node;
          w_nxt = in_edge_weight;
          idx_nxt = '0;
          res_status_nxt = ST_OK;
          res_dist_nxt = '0;
          res_pred_nxt = '0;
          res_found_nxt = 1'b0;
          res_cnt_nxt = '0;
          lh_ra = in_from_node;
          nm_ra = in_from_node;
          case (in_cmd_e)
            CMD_LOAD: begin
              if (a_oor || b_oor) res_status_nxt = ST_RANGE;
              else if (edge_full) res_status_nxt = ST_EDGE_FULL;
            end
            CMD_RUN:  if (a_oor || b_oor) res_status_nxt = ST_RANGE;
            CMD_READ: if (a_oor) res_status_nxt = ST_RANGE;
            default: ;
          endcase
        end
      end
      S_CLR: begin
        lh_we = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (sweep_last) edge_total_nxt = '0;
      end
      S_LOAD_D: begin
        // New edge goes to the front of the tail node's list.
        eg_we = 1'b1;
        lh_we = 1'b1;
        lh_wa = a_r;
        lh_wd = edge_total_r;
        edge_total_nxt = edge_total_r + 1'b1;
      end
      S_READ_D: begin
        res_dist_nxt = rd_dist;
        res_pred_nxt = rd_pred;
        res_found_nxt = (rd_dist != DIST_INF);
        res_cnt_nxt = last_settled_r;
      end
      S_RUN_CLR: begin
        nm_we = 1'b1;
        if (idx_r == a_r) nm_wd = {{DIST_W{1'b0}}, NODE_NONE};
        idx_nxt = idx_r + 1'b1;
        if (sweep_last) begin
          hp_we = 1'b1;
          hp_wa = '0;
          hp_wd = {{DIST_W{1'b0}}, a_r};
          fill_nxt = HFILL_W'(1);
          settled_nxt = '0;
          ovf_nxt = 1'b0;
        end
      end
      S_POP_CHK: hp_ra = '0;
      S_POP_TOP: begin
        pop_d_nxt = hp_rd[HENT_W-1 -: DIST_W];
        pop_u_nxt = hp_rd[NODE_W-1:0];
        hp_ra = HEAP_W'(fill_r - 1'b1);
        fill_nxt = fill_r - 1'b1;
      end
      S_POP_LAST: begin
        x_nxt = hp_rd;
        hi_nxt = '0;
      end
      S_SD_L: begin
        if (l_in) begin
          hp_ra = l_pos[HEAP_W-1:0];
          li_nxt = l_pos[HEAP_W-1:0];
          r_ok_nxt = r_in;
        end else begin
          hp_we = 1'b1;
        end
      end
      S_SD_R: begin
        lval_nxt = hp_rd;
        hp_ra = li_r + 1'b1;
      end
      S_SD_DEC: begin
        // The hole moves down to the smaller child until the moved entry fits.
        hp_we = 1'b1;
        if (r_lt) begin
          hp_wd = hp_rd;
          hi_nxt = li_r + 1'b1;
        end else if (l_lt_x) begin
          hp_wd = lval_r;
          hi_nxt = li_r;
        end
      end
      S_CHK: nm_ra = pop_u_r;
      S_CHK_D: begin
        lh_ra = pop_u_r;
        if (!stale && !over_cost) settled_nxt = settled_r + 1'b1;
      end
      S_HEAD_D: e_nxt = lh_rd;
      S_EDGE: ;
      S_EDGE_D: begin
        v_nxt = eg_rd[EENT_W-1 -: NODE_W];
        next_nxt = eg_rd[EPTR_W-1:0];
        new_dist_nxt = sat_add(pop_d_r, eg_rd[EPTR_W +: WGT_W]);
        nm_ra = eg_rd[EENT_W-1 -: NODE_W];
      end
      S_RELAX: begin
        e_nxt = next_r;
        if (better) begin
          nm_we = 1'b1;
          nm_wa = v_r;
          nm_wd = {new_dist_r, witness ? rd_pred : {1'b0, pop_u_r}};
          if (heap_full) begin
            ovf_nxt = 1'b1;
          end else begin
            hi_nxt = fill_r[HEAP_W-1:0];
            fill_nxt = fill_r + 1'b1;
            x_nxt = {new_dist_r, v_r};
          end
        end
      end
      S_SU: begin
        hp_ra = parent;
        if (hi_r == '0) hp_we = 1'b1;
      end
      S_SU_D: begin
        hp_we = 1'b1;
        if (su_up) begin
          hp_wd = hp_rd;
          hi_nxt = parent;
        end
      end
      S_FIN: begin
        nm_ra = b_r;
        last_settled_nxt = settled_r;
      end
      S_FIN_D: begin
        res_status_nxt = ovf_r ? ST_HEAP_OVF : ST_OK;
        res_dist_nxt = rd_dist;
        res_pred_nxt = rd_pred;
        res_found_nxt = (rd_dist != DIST_INF);
        res_cnt_nxt = settled_r;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = res_status_r;
          out_dist_nxt = res_dist_r;
          out_pred_nxt = res_pred_r;
          out_found_nxt = res_found_r;
          out_cnt_nxt = res_cnt_r;
        end
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RST_CLR;
      idx_r <= '0;
      out_valid_r <= 1'b0;
      edge_total_r <= '0;
      fill_r <= '0;
      last_settled_r <= '0;
      mode_r <= '0;
      cost_limit_r <= COST_W'(32'hFFFF_FFFE);
      max_settled_r <= NCNT_W'(MAX_NODES);
      node_count_r <= NCNT_W'(MAX_NODES);
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      edge_total_r <= edge_total_nxt;
      fill_r <= fill_nxt;
      last_settled_r <= last_settled_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_MODE:        mode_r <= cfg_wdata[MODE_W-1:0];
          CFG_COST_LIMIT:  cost_limit_r <= cfg_wdata[COST_W-1:0];
          CFG_MAX_SETTLED: max_settled_r <= cfg_wdata[NCNT_W-1:0];
          CFG_NODE_COUNT:  node_count_r <= cfg_wdata[NCNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    a_r <= a_nxt;  b_r <= b_nxt;  w_r <= w_nxt;
    settled_r <= settled_nxt;  ovf_r <= ovf_nxt;
    pop_d_r <= pop_d_nxt;  pop_u_r <= pop_u_nxt;  new_dist_r <= new_dist_nxt;  v_r <= v_nxt;
    x_r <= x_nxt;  lval_r <= lval_nxt;  hi_r <= hi_nxt;  li_r <= li_nxt;  r_ok_r <= r_ok_nxt;
    e_r <= e_nxt;  next_r <= next_nxt;
    res_status_r <= res_status_nxt;  res_dist_r <= res_dist_nxt;  res_pred_r <= res_pred_nxt;
    res_found_r <= res_found_nxt;  res_cnt_r <= res_cnt_nxt;
    out_status_r <= out_status_nxt;  out_dist_r <= out_dist_nxt;  out_pred_r <= out_pred_nxt;
    out_found_r <= out_found_nxt;  out_cnt_r <= out_cnt_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_distance      = out_dist_r;
  assign out_predecessor   = out_pred_r;
  assign out_found         = out_found_r;
  assign out_settled_count = out_cnt_r;

endmodule

// ===== design/dsp_checker.sv =====
// Port-level checks for the shortest-path engine, bound to the top level.
module dsp_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       out_found,
  input logic [dsp_pkg::DIST_W-1:0] out_distance
);
  import dsp_pkg::*;

  // A held result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // The block is busy in the cycle after it takes a request.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken back to back");

  // Reset starts the table sweep with no result pending.
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("block open right after reset");

  // A reached node never reports the unreached distance.
  a_found_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_distance != DIST_INF)
    else $error("found with unreached distance");

endmodule

bind dijkstra_shortest_path dsp_checker u_dsp_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_found(out_found),
  .out_distance(out_distance)
);
